### rtl/core/crmdb_pkg.sv
`timescale 1ns / 1ps

package crmdb_pkg;

    localparam int MAX_HALF_WINDOW = 31;
    localparam int HIST_DEPTH      = 2 * MAX_HALF_WINDOW + 1;
    localparam int ADDR_W          = $clog2(HIST_DEPTH);
    localparam int CNT_W           = $clog2(HIST_DEPTH + 1);

    localparam int LEVEL_W = 15;
    localparam int PWR_W   = 54;    // largest power term stays below 2^54
    localparam int SUM_W   = 60;    // up to 63 terms
    localparam int ENTRY_W = PWR_W + 1;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [30:0] LOG2_10_OVER_10_Q32 = 31'd1426757253;
    localparam logic [29:0] LN2_Q30             = 30'd744261118;
    localparam logic [25:0] DB_PER_LOG2_Q16     = 26'd50504453;
    localparam logic [5:0]  LAST_TERM           = 6'd16;
    localparam logic [5:0]  SHIFT_BIAS          = 6'd20;

    localparam logic [2:0]  REG_WIN_LEN = 3'd0;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_PE   = 15'b000000000000010,
        ST_PU   = 15'b000000000000100,
        ST_PY   = 15'b000000000001000,
        ST_TY   = 15'b000000000010000,
        ST_TN   = 15'b000000000100000,
        ST_PADD = 15'b000000001000000,
        ST_WR   = 15'b000000010000000,
        ST_RD   = 15'b000000100000000,
        ST_ACC  = 15'b000001000000000,
        ST_DIV  = 15'b000010000000000,
        ST_NORM = 15'b000100000000000,
        ST_SQ   = 15'b001000000000000,
        ST_DB   = 15'b010000000000000,
        ST_RND  = 15'b100000000000000
    } t_state;

    // reciprocal of the taylor divisor n, exact for dividends below 2^30
    function automatic logic [31:0] f_recip(input logic [5:0] n);
        logic [31:0] m;
        case (n)
            6'd3:    m = 32'd1431655766;
            6'd5:    m = 32'd1717986919;
            6'd6:    m = 32'd1431655766;
            6'd7:    m = 32'd1227133514;
            6'd9:    m = 32'd1908874354;
            6'd10:   m = 32'd1717986919;
            6'd11:   m = 32'd1561806290;
            6'd12:   m = 32'd1431655766;
            6'd13:   m = 32'd1321528399;
            6'd14:   m = 32'd1227133514;
            6'd15:   m = 32'd1145324613;
            default: m = 32'd1073741824;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] f_rshift(input logic [5:0] n);
        logic [5:0] k;
        case (n)
            6'd2:                      k = 6'd31;
            6'd3, 6'd4:                k = 6'd32;
            6'd5, 6'd6, 6'd7, 6'd8:    k = 6'd33;
            default:                   k = 6'd34;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/crmdb_ram.sv
`timescale 1ns / 1ps

module crmdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/centered_rolling_mean_db.sv
`timescale 1ns / 1ps
// sequence: power term per sample (a missing one skips it), then per result a history sweep,
//   divider, normalize, squaring loop, log scaling multiply and rounding
// throughput: a new sample is taken only when idle, after every result it causes is loaded;
//   a result whose window holds a missing sample skips from the sweep to rounding; the pace is
//   set by the single shared multiplier and the one-bit-per-cycle divider and normalizer
// reset: synchronous active-low, clears sequencer, counters and window size (to 1)
// history ram needs no clearing; only entries of the current series are read
module centered_rolling_mean_db (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [14:0] i_level_db,
    input  logic               i_is_missing,
    input  logic               i_last_sample,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_mean_db,
    output logic               o_result_missing,
    output logic               o_last_result,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = crmdb_pkg::ADDR_W;
    localparam int CW = crmdb_pkg::CNT_W;

    crmdb_pkg::t_state r_state, n_state;

    // control
    logic [5:0]    r_ws, n_ws;
    logic [CW-1:0] r_ss, n_ss;          // samples seen in the series
    logic [CW-1:0] r_cnt, n_cnt;        // count after the current sample
    logic [AW-1:0] r_wr_pos, n_wr_pos;
    logic [AW-1:0] r_raddr, n_raddr;
    logic [CW-1:0] r_d, n_d;
    logic [CW-1:0] r_top, n_top;
    logic [CW-1:0] r_j, n_j;
    logic          r_flush, n_flush;
    logic          r_lflag, n_lflag;
    logic [5:0]    r_n, n_n;
    logic [5:0]    r_it, n_it;
    logic [5:0]    r_p, n_p;
    logic          r_out_valid, n_out_valid;

    // payload
    logic signed [14:0]                 r_x, n_x;
    logic                               r_miss_in, n_miss_in;
    logic                               r_last_in, n_last_in;
    logic signed [crmdb_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [5:0]                         r_ip, n_ip;
    logic [29:0]                        r_f30, n_f30;
    logic [29:0]                        r_y, n_y;
    logic [29:0]                        r_t, n_t;
    logic [31:0]                        r_m, n_m;
    logic [crmdb_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic                               r_miss, n_miss;
    logic [5:0]                         r_rem, n_rem;
    logic [crmdb_pkg::SUM_W-1:0]        r_quo, n_quo;
    logic [30:0]                        r_mm, n_mm;
    logic [23:0]                        r_frac, n_frac;
    logic signed [14:0]                 r_out_db, n_out_db;
    logic                               r_out_miss, n_out_miss;
    logic                               r_out_last, n_out_last;

    // shared multiplier
    logic signed [crmdb_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [crmdb_pkg::PROD_W-1:0] mul_p;
    logic [crmdb_pkg::PROD_W-1:0]        mul_u;

    // history ram
    logic                            ram_we;
    logic [AW-1:0]                   ram_raddr;
    logic [crmdb_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

    logic [CW-1:0]  h, span, ss_new;
    logic           cfg_wr;
    logic [45:0]    u_val;
    logic [crmdb_pkg::PWR_W-1:0] pwr;
    logic [crmdb_pkg::PWR_W-1:0] rd_pwr;
    logic           rd_miss;
    logic [crmdb_pkg::SUM_W-1:0] acc;
    logic [6:0]     rem2, divisor;
    logic           qbit;
    logic [crmdb_pkg::SUM_W-1:0] quo_new;
    logic [31:0]    sq;
    logic signed [30:0] l2;
    logic [6:0]     pm32;
    logic signed [crmdb_pkg::PROD_W-1:0] rnd;
    logic signed [14:0] db_sat;
    logic           can_load;
    logic [CW-1:0]  j0, jn;

    function automatic logic [CW-1:0] f_min(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(crmdb_pkg::HIST_DEPTH - 1) : a - AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(crmdb_pkg::HIST_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    assign h      = CW'(r_ws >> 1);
    assign span   = (h << 1) + CW'(1);
    assign ss_new = (r_ss < span) ? r_ss + CW'(1) : r_ss;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr == crmdb_pkg::REG_WIN_LEN) ? {26'd0, r_ws} : 32'd0;

    assign o_in_ready       = (r_state == crmdb_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_mean_db        = r_out_db;
    assign o_result_missing = r_out_miss;
    assign o_last_result    = r_out_last;

    // multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            crmdb_pkg::ST_PE: begin
                mul_a = {{18{r_x[14]}}, r_x};
                mul_b = {2'b00, crmdb_pkg::LOG2_10_OVER_10_Q32};
            end
            crmdb_pkg::ST_PY: begin
                mul_a = {3'b000, r_f30};
                mul_b = {3'b000, crmdb_pkg::LN2_Q30};
            end
            crmdb_pkg::ST_TY: begin
                mul_a = {3'b000, r_t};
                mul_b = {3'b000, r_y};
            end
            crmdb_pkg::ST_TN: begin
                mul_a = {3'b000, r_t};
                mul_b = {1'b0, crmdb_pkg::f_recip(r_n)};
            end
            crmdb_pkg::ST_SQ: begin
                mul_a = {2'b00, r_mm};
                mul_b = {2'b00, r_mm};
            end
            crmdb_pkg::ST_DB: begin
                mul_a = {{2{l2[30]}}, l2};
                mul_b = {7'd0, crmdb_pkg::DB_PER_LOG2_Q16};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign mul_u = mul_p;

    // exponent split of x*log2(10)/10, biased positive
    assign u_val = r_prod[45:0] + (46'd22 << 40);

    // mantissa scaled by 2^(ip-20)
    always_comb begin
        if (r_ip >= crmdb_pkg::SHIFT_BIAS) begin
            pwr = {22'd0, r_m} << (r_ip - crmdb_pkg::SHIFT_BIAS);
        end else begin
            pwr = {22'd0, r_m} >> (crmdb_pkg::SHIFT_BIAS - r_ip);
        end
    end

    assign ram_wdata = {r_miss_in, pwr};
    assign ram_we    = (r_state == crmdb_pkg::ST_WR);
    assign ram_raddr = (r_state == crmdb_pkg::ST_RD) ? f_dec(r_wr_pos) : f_dec(r_raddr);
    assign rd_miss   = ram_rdata[crmdb_pkg::ENTRY_W-1];
    assign rd_pwr    = ram_rdata[crmdb_pkg::PWR_W-1:0];
    assign acc       = r_sum + (rd_miss ? '0 : crmdb_pkg::SUM_W'(rd_pwr));

    // restoring divide step
    assign divisor = 7'(r_top) + 7'd1;
    assign rem2    = {r_rem, r_quo[crmdb_pkg::SUM_W-1]};
    assign qbit    = (rem2 >= divisor);
    assign quo_new = {r_quo[crmdb_pkg::SUM_W-2:0], qbit};

    assign sq   = mul_u[61:30];
    assign pm32 = 7'(r_p) - 7'd32;
    assign l2   = $signed({pm32, r_frac});

    // round half up, then clamp to the 15-bit signed q7.8 range
    assign rnd = r_prod + (crmdb_pkg::PROD_W'(1) << 39);
    always_comb begin
        logic signed [crmdb_pkg::PROD_W-1:0] q;
        q = rnd >>> 40;
        if (q[crmdb_pkg::PROD_W-1:14] == '0 || q[crmdb_pkg::PROD_W-1:14] == '1) begin
            db_sat = q[14:0];
        end else if (q[crmdb_pkg::PROD_W-1]) begin
            db_sat = 15'sh4000;
        end else begin
            db_sat = 15'sh3fff;
        end
    end

    assign can_load = !r_out_valid || i_out_ready;
    assign j0       = f_min(h - CW'(1), ss_new - CW'(1));
    assign jn       = f_min(h - CW'(1), r_cnt - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_ws        = r_ws;
        n_ss        = r_ss;
        n_cnt       = r_cnt;
        n_wr_pos    = r_wr_pos;
        n_raddr     = r_raddr;
        n_d         = r_d;
        n_top       = r_top;
        n_j         = r_j;
        n_flush     = r_flush;
        n_lflag     = r_lflag;
        n_n         = r_n;
        n_it        = r_it;
        n_p         = r_p;
        n_out_valid = r_out_valid && !i_out_ready;
        n_x         = r_x;
        n_miss_in   = r_miss_in;
        n_last_in   = r_last_in;
        n_prod      = r_prod;
        n_ip        = r_ip;
        n_f30       = r_f30;
        n_y         = r_y;
        n_t         = r_t;
        n_m         = r_m;
        n_sum       = r_sum;
        n_miss      = r_miss;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_mm        = r_mm;
        n_frac      = r_frac;
        n_out_db    = r_out_db;
        n_out_miss  = r_out_miss;
        n_out_last  = r_out_last;

        case (r_state)
            crmdb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_x       = i_level_db;
                    n_miss_in = i_is_missing;
                    n_last_in = i_last_sample;
                    n_state   = i_is_missing ? crmdb_pkg::ST_WR : crmdb_pkg::ST_PE;
                end
            end
            crmdb_pkg::ST_PE: begin
                n_prod  = mul_p;
                n_state = crmdb_pkg::ST_PU;
            end
            crmdb_pkg::ST_PU: begin
                n_ip    = u_val[45:40];
                n_f30   = u_val[39:10];
                n_state = crmdb_pkg::ST_PY;
            end
            crmdb_pkg::ST_PY: begin
                n_y     = mul_u[59:30];
                n_t     = mul_u[59:30];
                n_m     = 32'd1 << 30;
                n_n     = 6'd2;
                n_state = crmdb_pkg::ST_TY;
            end
            crmdb_pkg::ST_TY: begin
                n_t     = mul_u[59:30];
                n_m     = r_m + 32'(r_t);
                n_state = crmdb_pkg::ST_TN;
            end
            crmdb_pkg::ST_TN: begin
                n_t     = 30'(mul_u >> crmdb_pkg::f_rshift(r_n));
                n_n     = r_n + 6'd1;
                n_state = (r_n == crmdb_pkg::LAST_TERM) ? crmdb_pkg::ST_PADD
                                                        : crmdb_pkg::ST_TY;
            end
            crmdb_pkg::ST_PADD: begin
                n_m     = r_m + 32'(r_t);
                n_state = crmdb_pkg::ST_WR;
            end
            crmdb_pkg::ST_WR: begin
                n_wr_pos = f_inc(r_wr_pos);
                n_cnt    = ss_new;
                n_ss     = r_last_in ? '0 : ss_new;
                if (ss_new >= h + CW'(1)) begin
                    // centered result for the sample h back
                    n_top   = f_min(h << 1, ss_new - CW'(1));
                    n_lflag = r_last_in && (h == '0);
                    n_flush = 1'b0;
                    n_state = crmdb_pkg::ST_RD;
                end else if (r_last_in && h != '0) begin
                    n_j     = j0;
                    n_top   = f_min(j0 + h, ss_new - CW'(1));
                    n_lflag = (j0 == '0);
                    n_flush = 1'b1;
                    n_state = crmdb_pkg::ST_RD;
                end else begin
                    n_state = crmdb_pkg::ST_IDLE;
                end
            end
            crmdb_pkg::ST_RD: begin
                n_raddr = ram_raddr;
                n_d     = '0;
                n_sum   = '0;
                n_miss  = 1'b0;
                n_state = crmdb_pkg::ST_ACC;
            end
            crmdb_pkg::ST_ACC: begin
                n_sum  = acc;
                n_miss = r_miss || rd_miss;
                if (r_d == r_top) begin
                    n_quo   = acc;
                    n_rem   = '0;
                    n_it    = '0;
                    n_state = (r_miss || rd_miss) ? crmdb_pkg::ST_RND : crmdb_pkg::ST_DIV;
                end else begin
                    n_d     = r_d + CW'(1);
                    n_raddr = ram_raddr;
                end
            end
            crmdb_pkg::ST_DIV: begin
                n_rem = qbit ? 6'(rem2 - divisor) : rem2[5:0];
                n_quo = quo_new;
                n_it  = r_it + 6'd1;
                if (r_it == 6'(crmdb_pkg::SUM_W - 1)) begin
                    // a zero mean is taken as one lsb
                    n_quo   = (quo_new == '0) ? crmdb_pkg::SUM_W'(1) : quo_new;
                    n_p     = 6'(crmdb_pkg::SUM_W - 1);
                    n_state = crmdb_pkg::ST_NORM;
                end
            end
            crmdb_pkg::ST_NORM: begin
                if (r_quo[crmdb_pkg::SUM_W-1] || r_p == '0) begin
                    n_mm    = r_quo[crmdb_pkg::SUM_W-1 -: 31];
                    n_it    = '0;
                    n_frac  = '0;
                    n_state = crmdb_pkg::ST_SQ;
                end else begin
                    n_quo = r_quo << 1;
                    n_p   = r_p - 6'd1;
                end
            end
            crmdb_pkg::ST_SQ: begin
                if (sq[31]) begin
                    n_frac = {r_frac[22:0], 1'b1};
                    n_mm   = sq[31:1];
                end else begin
                    n_frac = {r_frac[22:0], 1'b0};
                    n_mm   = sq[30:0];
                end
                n_it = r_it + 6'd1;
                if (r_it == 6'd23) begin
                    n_state = crmdb_pkg::ST_DB;
                end
            end
            crmdb_pkg::ST_DB: begin
                n_prod  = mul_p;
                n_state = crmdb_pkg::ST_RND;
            end
            crmdb_pkg::ST_RND: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_db    = r_miss ? 15'sd0 : db_sat;
                    n_out_miss  = r_miss;
                    n_out_last  = r_lflag;
                    if (!r_flush) begin
                        if (r_last_in && h != '0) begin
                            n_j     = jn;
                            n_top   = f_min(jn + h, r_cnt - CW'(1));
                            n_lflag = (jn == '0);
                            n_flush = 1'b1;
                            n_state = crmdb_pkg::ST_RD;
                        end else begin
                            n_state = crmdb_pkg::ST_IDLE;
                        end
                    end else if (r_j == '0) begin
                        n_state = crmdb_pkg::ST_IDLE;
                    end else begin
                        n_j     = r_j - CW'(1);
                        n_top   = f_min(r_j - CW'(1) + h, r_cnt - CW'(1));
                        n_lflag = (r_j == CW'(1));
                        n_state = crmdb_pkg::ST_RD;
                    end
                end
            end
            default: begin
                n_state = crmdb_pkg::ST_IDLE;
            end
        endcase

        // register write restarts the series
        if (cfg_wr && paddr == crmdb_pkg::REG_WIN_LEN) begin
            n_ws = pwdata[5:0];
            n_ss = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crmdb_pkg::ST_IDLE;
            r_ws        <= 6'd1;
            r_ss        <= '0;
            r_cnt       <= '0;
            r_wr_pos    <= '0;
            r_raddr     <= '0;
            r_d         <= '0;
            r_top       <= '0;
            r_j         <= '0;
            r_flush     <= 1'b0;
            r_lflag     <= 1'b0;
            r_n         <= '0;
            r_it        <= '0;
            r_p         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ws        <= n_ws;
            r_ss        <= n_ss;
            r_cnt       <= n_cnt;
            r_wr_pos    <= n_wr_pos;
            r_raddr     <= n_raddr;
            r_d         <= n_d;
            r_top       <= n_top;
            r_j         <= n_j;
            r_flush     <= n_flush;
            r_lflag     <= n_lflag;
            r_n         <= n_n;
            r_it        <= n_it;
            r_p         <= n_p;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_miss_in  <= n_miss_in;
        r_last_in  <= n_last_in;
        r_prod     <= n_prod;
        r_ip       <= n_ip;
        r_f30      <= n_f30;
        r_y        <= n_y;
        r_t        <= n_t;
        r_m        <= n_m;
        r_sum      <= n_sum;
        r_miss     <= n_miss;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_mm       <= n_mm;
        r_frac     <= n_frac;
        r_out_db   <= n_out_db;
        r_out_miss <= n_out_miss;
        r_out_last <= n_out_last;
    end

    crmdb_ram #(
        .WIDTH (crmdb_pkg::ENTRY_W),
        .DEPTH (crmdb_pkg::HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_pos),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // history sweep never runs past the window
    a_sweep_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crmdb_pkg::ST_ACC |-> r_d <= r_top)
        else $error("history sweep past window top");

    // divider remainder stays below the window count
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crmdb_pkg::ST_DIV |-> 7'(r_rem) < divisor)
        else $error("divider remainder out of range");

    // log mantissa stays normalized through the squaring loop
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crmdb_pkg::ST_SQ |-> r_mm[30])
        else $error("log mantissa lost normalization");

    // sample count saturates at the span
    a_ss_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crmdb_pkg::ST_WR |=> r_ss <= span)
        else $error("sample count beyond window span");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // one sample beat and one result beat
    typedef struct packed {
        logic signed [14:0] level;
        logic               missing;
        logic               last;
    } t_sample;

    typedef struct packed {
        logic signed [14:0] mean;
        logic               missing;
        logic               last;
    } t_mean;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;    // covers one power term plus a full result
    localparam logic [2:0] REG_UNMAPPED = 3'd1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [14:0] i_level_db;
    logic               i_is_missing;
    logic               i_last_sample;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [14:0] o_mean_db;
    logic               o_result_missing;
    logic               o_last_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    centered_rolling_mean_db DUT (.*);

    // clock, 8 ns period
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    t_sample sample_q[$];     // samples waiting for the driver
    t_mean   mean_q[$];       // means the block still owes us
    int      err_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      idle_cycles;
    logic    in_taken;

    // shadow of the block: history ring, series count and window register
    t_sample    hist [crmdb_pkg::HIST_DEPTH];
    int         hist_wr;
    int         series_len;
    logic [5:0] win_size;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // 10^(x/10) in Q22.32, via 2^e with a taylor series for the fraction
    function automatic logic [63:0] db_to_power(input logic signed [14:0] x);
        longint signed e;
        logic [63:0]   u, f30, y, m, t;
        int            ip, s;
        e   = longint'(x) * longint'(crmdb_pkg::LOG2_10_OVER_10_Q32);
        u   = e + (64'sd22 <<< 40);
        ip  = int'(u >> 40);
        f30 = (u & ((64'd1 << 40) - 1)) >> 10;
        y   = (f30 * 64'(crmdb_pkg::LN2_Q30)) >> 30;
        m   = (64'd1 << 30) + y;
        t   = y;
        for (int n = 2; n <= 16; n++) begin
            t = ((t * y) >> 30) / n;
            m += t;
        end
        s = ip - 20;
        return (s >= 0) ? (m << s) : (m >> (-s));
    endfunction

    // 10*log10 of a Q22.32 power, rounded half up and saturated to 15-bit signed Q7.8
    function automatic logic signed [14:0] power_to_db(input logic [63:0] a);
        int            p;
        logic [63:0]   mm;
        longint signed frac, l2, v, q;
        frac = 0;
        if (a == 0) a = 1;
        p = 63;
        while (p > 0 && !a[p]) p--;
        mm = (p >= 30) ? (a >> (p - 30)) : (a << (30 - p));
        for (int i = 0; i < 24; i++) begin
            mm   = (mm * mm) >> 30;
            frac = frac <<< 1;
            if (mm >= (64'd1 << 31)) begin
                frac |= 1;
                mm >>= 1;
            end
        end
        l2 = longint'(p - 32) * 64'sd16777216 + frac;
        v  = l2 * longint'(crmdb_pkg::DB_PER_LOG2_Q16) + (64'sd1 <<< 39) + (64'sd1 <<< 55);
        q  = (v >>> 40) - 64'sd32768;
        if (q > 16383) q = 16383;
        if (q < -16384) q = -16384;
        return q[14:0];
    endfunction

    // mean over history offsets 0..top back from the newest sample
    task automatic push_window_mean(input int top, input logic last);
        logic [63:0] psum;
        int          misses;
        int          idx;
        t_mean       r;
        psum   = 0;
        misses = 0;
        for (int d = 0; d <= top; d++) begin
            idx = (hist_wr + 2 * crmdb_pkg::HIST_DEPTH - 1 - d) % crmdb_pkg::HIST_DEPTH;
            if (hist[idx].missing) misses++;
            else psum += db_to_power(hist[idx].level);
        end
        r.missing = (misses != 0);
        r.mean    = r.missing ? 15'sd0 : power_to_db(psum / (top + 1));
        r.last    = last;
        mean_q.push_back(r);
    endtask

    // what one accepted sample makes the block emit
    task automatic predict_sample(input t_sample smp);
        int hw, span, top, j;
        hw   = (win_size / 2 > crmdb_pkg::MAX_HALF_WINDOW) ? crmdb_pkg::MAX_HALF_WINDOW
                                                           : win_size / 2;
        span = 2 * hw + 1;
        hist[hist_wr] = smp;
        hist_wr = (hist_wr + 1) % crmdb_pkg::HIST_DEPTH;
        if (series_len < span) series_len++;
        if (series_len >= hw + 1) begin
            top = (2 * hw < series_len - 1) ? 2 * hw : series_len - 1;
            push_window_mean(top, smp.last && hw == 0);
        end
        if (smp.last) begin
            // flush the tail, the window shrinking toward the series end
            if (hw != 0) begin
                j = (hw - 1 < series_len - 1) ? hw - 1 : series_len - 1;
                forever begin
                    top = (j + hw < series_len - 1) ? j + hw : series_len - 1;
                    push_window_mean(top, j == 0);
                    if (j == 0) break;
                    j--;
                end
            end
            series_len = 0;
        end
    endtask

    // sample driver: holds a beat until taken, idles at random between beats
    always @(negedge i_clk) begin
        t_sample nx;
        if (i_in_valid && !in_taken) begin
            // beat still waiting, hold it
        end else if (i_rst_n && sample_q.size() != 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            nx = sample_q.pop_front();
            i_in_valid    <= 1'b1;
            i_level_db    <= nx.level;
            i_is_missing  <= nx.missing;
            i_last_sample <= nx.last;
        end else begin
            i_in_valid <= 1'b0;
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on sample beats, check result beats, watch for a hang
    always @(posedge i_clk) begin
        t_mean got, want;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_sample(t_sample'{i_level_db, i_is_missing, i_last_sample});
            if (o_out_valid && i_out_ready) begin
                got = t_mean'{o_mean_db, o_result_missing, o_last_result};
                if (mean_q.size() == 0) begin
                    report_mismatch("unexpected result, mean_db", got.mean, 0);
                end else begin
                    want = mean_q.pop_front();
                    if (got.mean !== want.mean)
                        report_mismatch("mean_db", got.mean, want.mean);
                    if (got.missing !== want.missing)
                        report_mismatch("result_missing", got.missing, want.missing);
                    if (got.last !== want.last)
                        report_mismatch("last_result", got.last, want.last);
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // sender holds off until every owed result is back, then the block settles
    task automatic wait_drained();
        while (sample_q.size() != 0 || i_in_valid || mean_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write then read-back over the apb port
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = idx << 2;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (idx == crmdb_pkg::REG_WIN_LEN) begin
            win_size   = value[5:0];
            series_len = 0;
        end
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = crmdb_pkg::REG_WIN_LEN;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[5:0] !== win_size)
            report_mismatch("win len readback", prdata[5:0], win_size);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic add_sample(input int level, input logic missing, input logic last);
        sample_q.push_back(t_sample'{15'(level), missing, last});
    endtask

    // random series: mostly clean windows, some gaps, random series lengths
    task automatic add_random(input int count, input int miss_pct, input int last_pct);
        for (int k = 0; k < count; k++)
            add_sample($urandom_range(32767), $urandom_range(99) < miss_pct,
                       (k == count - 1) || ($urandom_range(99) < last_pct));
    endtask

    initial begin
        int wins [7];
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_level_db     = '0;
        i_is_missing   = 1'b0;
        i_last_sample  = 1'b0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_taken       = 1'b0;
        err_count      = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hist_wr        = 0;
        series_len     = 0;
        win_size       = 6'd1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset window of one: every sample is its own mean, extremes of level
        add_sample(16383, 1'b0, 1'b0);
        add_sample(-16384, 1'b0, 1'b0);
        add_sample(0, 1'b0, 1'b0);
        add_sample(-1, 1'b1, 1'b0);
        add_sample(256, 1'b0, 1'b1);
        wait_drained();

        // window zero degenerates to half-width zero
        write_reg(crmdb_pkg::REG_WIN_LEN, 0);
        add_sample(-2560, 1'b0, 1'b0);
        add_sample(12800, 1'b0, 1'b1);
        wait_drained();

        // half-width two: single-sample and two-sample series, missing in middle
        write_reg(crmdb_pkg::REG_WIN_LEN, 5);
        add_sample(1000, 1'b0, 1'b1);
        add_sample(-3000, 1'b0, 1'b0);
        add_sample(5000, 1'b0, 1'b1);
        add_sample(100, 1'b0, 1'b0);
        add_sample(200, 1'b0, 1'b0);
        add_sample(300, 1'b1, 1'b0);
        add_sample(400, 1'b0, 1'b0);
        add_sample(500, 1'b0, 1'b0);
        add_sample(600, 1'b0, 1'b1);
        wait_drained();

        // write beyond the register list is dropped, window stays at five
        write_reg(REG_UNMAPPED, 32'd10);
        add_sample(-700, 1'b0, 1'b0);
        add_sample(7000, 1'b0, 1'b1);
        wait_drained();

        // largest window, capped half-width, short series flush
        write_reg(crmdb_pkg::REG_WIN_LEN, 63);
        add_sample(16383, 1'b0, 1'b0);
        add_sample(16383, 1'b0, 1'b0);
        add_sample(-16384, 1'b0, 1'b1);
        wait_drained();

        // random phases over window settings and idle modes
        wins = '{2, 63, 62, 3, 0, 8, 1};
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(crmdb_pkg::REG_WIN_LEN, (ph == 4) ? $urandom_range(63) : wins[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            add_random(28, (ph == 5) ? 0 : 4, 8);
            // a phase that ends mid-series: the next write drops the owed tail
            if (ph == 3) begin
                add_random(6, 0, 0);
                sample_q[sample_q.size() - 1].last = 1'b0;
            end
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
